FILE: rtl/rfe_pkg.sv
// Shared types, constants and cosine table generator for the Rastrigin evaluator.
package rfe_pkg;

    localparam int COORD_W   = 16;
    localparam int SQ_W      = 19;
    localparam int ROM_IDX_W = 13;
    localparam int COS_W     = 13;
    localparam int FIT_W     = 32;
    localparam int DIM_W     = 11;
    localparam int ONE_Q12   = 4096;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [SQ_W-1:0]      sq;
        logic [ROM_IDX_W-1:0] idx;
        logic                 neg;
        logic                 last;
    } rfe_op_t;

    // Q30 Taylor series of cos(t), rounded to Q12 and clamped to [0, 1.0].
    function automatic logic [COS_W-1:0] cos_taylor_q12(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        t2   = (t * t) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        v = (sum > 0) ? ((sum + 64'sd131072) >>> 18) : 64'sd0;
        if (v > ONE_Q12) begin
            v = ONE_Q12;
        end
        return v[COS_W-1:0];
    endfunction

endpackage

FILE: rtl/rfe_front.sv
// Front end: accepts coordinates, squares them and forms the cosine table lookup.
module rfe_front #(
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [15:0]             s_axis_tdata,   // [15:0] coord
    input  logic                    s_axis_tlast,
    output logic                    push_valid,
    output rfe_pkg::rfe_op_t        push_data,
    input  logic                    queue_full
);
    import rfe_pkg::*;

    logic                    f_valid_reg, f_valid_next;
    logic [30:0]             f_prod_reg;
    logic [ROM_IDX_W-1:0]    f_idx_reg;
    logic                    f_neg_reg;
    logic                    f_last_reg;

    logic signed [COORD_W-1:0] coord;
    logic signed [31:0]        prod;
    logic [1:0]                quad;
    logic [9:0]                r;
    logic [10:0]               m;
    logic [24:0]               scaled;
    logic [30:0]               rounded;
    logic                      accept;
    logic                      push;

    assign coord   = s_axis_tdata[COORD_W-1:0];
    assign prod    = 32'(coord) * 32'(coord);
    assign quad    = s_axis_tdata[11:10];
    assign r       = s_axis_tdata[9:0];
    assign m       = quad[0] ? (11'd1024 - {1'b0, r}) : {1'b0, r};
    assign scaled  = ({14'd0, m} * 25'(COS_TABLE_DEPTH) + 25'd512) >> 10;

    assign push          = f_valid_reg && !queue_full;
    assign s_axis_tready = !f_valid_reg || !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_prod_reg <= prod[30:0];
            f_idx_reg  <= scaled[ROM_IDX_W-1:0];
            f_neg_reg  <= quad[1] ^ quad[0];
            f_last_reg <= s_axis_tlast;
        end
    end

    assign rounded        = f_prod_reg + 31'd2048;
    assign push_valid     = push;
    assign push_data.sq   = rounded[30:12];
    assign push_data.idx  = f_idx_reg;
    assign push_data.neg  = f_neg_reg;
    assign push_data.last = f_last_reg;

endmodule

FILE: rtl/rfe_queue.sv
// Small register queue between the front end and the back end.
module rfe_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/rfe_back.sv
// Back end: cosine table read, saturating accumulation and final result register.
module rfe_back #(
    parameter int MAX_DIM         = 1024,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  rfe_pkg::rfe_op_t        q_data,
    output logic                    q_pop,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [47:0]             m_axis_tdata    // [31:0] fitness, [42:32] dimension,
                                                    // [43] saturated
);
    import rfe_pkg::*;

    localparam int RIW = $clog2(COS_TABLE_DEPTH + 1);
    localparam logic signed [32:0] SUM_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] SUM_MIN = -33'sh0_8000_0000;

    logic [COS_W-1:0] cos_rom [COS_TABLE_DEPTH+1];

    for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] T =
            (64'(k) * HALF_PI_Q30 + 64'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
        assign cos_rom[k] = cos_taylor_q12(T);
    end

    logic                    en;

    logic                    b1_valid_reg;
    rfe_op_t                 b1_op_reg;
    logic [COS_W-1:0]        b1_cos_reg;

    logic signed [FIT_W-1:0] sum_reg, sum_next;
    logic [DIM_W-1:0]        cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;

    logic                    fin_valid_reg;
    logic signed [FIT_W-1:0] fin_sum_reg;
    logic [DIM_W-1:0]        fin_cnt_reg;
    logic                    fin_ovf_reg;

    logic                    out_valid_reg;
    logic signed [FIT_W-1:0] out_fit_reg, out_fit_next;
    logic [DIM_W-1:0]        out_dim_reg;
    logic                    out_sat_reg, out_sat_next;

    logic [16:0]             ten_cos;
    logic signed [20:0]      sq_s;
    logic signed [20:0]      term;
    logic signed [32:0]      acc_wide;
    logic signed [FIT_W-1:0] acc_sat;
    logic                    acc_ovf;
    logic [32:0]             dim_bias;
    logic signed [32:0]      fin_wide;

    assign en    = !out_valid_reg || m_axis_tready;
    assign q_pop = en && !q_empty;

    // stage 1: table read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (en) begin
            b1_valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_op_reg  <= q_data;
            b1_cos_reg <= cos_rom[q_data.idx[RIW-1:0]];
        end
    end

    // stage 2: accumulate
    assign ten_cos  = {1'b0, b1_cos_reg, 3'b000} + {3'b000, b1_cos_reg, 1'b0};
    assign sq_s     = {2'b00, b1_op_reg.sq};
    assign term     = b1_op_reg.neg ? (sq_s + {4'b0000, ten_cos})
                                    : (sq_s - {4'b0000, ten_cos});
    assign acc_wide = {sum_reg[FIT_W-1], sum_reg} + {{12{term[20]}}, term};
    assign acc_ovf  = acc_wide[32] != acc_wide[31];
    assign acc_sat  = !acc_ovf ? acc_wide[31:0]
                    : (acc_wide[32] ? SUM_MIN[31:0] : SUM_MAX[31:0]);

    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg | acc_ovf;
        if (cnt_reg < DIM_W'(MAX_DIM)) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            ovf_next = 1'b1;
        end
        sum_next = acc_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= b1_valid_reg && b1_op_reg.last;
            if (b1_valid_reg) begin
                if (b1_op_reg.last) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && b1_valid_reg && b1_op_reg.last) begin
            fin_sum_reg <= sum_next;
            fin_cnt_reg <= cnt_next;
            fin_ovf_reg <= ovf_next;
        end
    end

    // stage 3: add 10*n in Q.12 and register the result
    assign dim_bias = ({22'd0, fin_cnt_reg} << 15) + ({22'd0, fin_cnt_reg} << 13);
    assign fin_wide = {fin_sum_reg[FIT_W-1], fin_sum_reg} + $signed(dim_bias);

    always_comb begin
        out_fit_next = fin_wide[31:0];
        out_sat_next = fin_ovf_reg;
        if (fin_wide[32] != fin_wide[31]) begin
            out_fit_next = fin_wide[32] ? SUM_MIN[31:0] : SUM_MAX[31:0];
            out_sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && fin_valid_reg) begin
            out_fit_reg <= out_fit_next;
            out_dim_reg <= fin_cnt_reg;
            out_sat_reg <= out_sat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_sat_reg, out_dim_reg, out_fit_reg};

endmodule

FILE: rtl/rastrigin_fitness_evaluator_core.sv
// Rastrigin fitness evaluator: top level joining front end, queue and back end.
//
// Input stream s_axis: one Q4.12 coordinate per transaction in tdata[15:0];
// tlast marks the final coordinate of a candidate vector.
// Output stream m_axis: one transaction per vector, carrying the Q20.12
// fitness, the coordinate count and a saturation flag.
// Throughput: one coordinate per cycle while the queue has room and the receiver
// keeps up; square, table read and accumulate each sit in a stage of their own.
// The last coordinate passes the front register, queue, table read,
// accumulate and result register before the result appears.
// A four-entry queue sits between the front end and the back end; when the
// receiver stalls the back end holds its result and the front end keeps
// taking coordinates until the queue fills, then drops s_axis_tready.
// Reset (aresetn low, synchronous) empties the pipeline and clears the
// running sum, the count and the saturation flag.
module rastrigin_fitness_evaluator_core #(
    parameter int MAX_DIM         = 1024,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] coord
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [31:0] fitness, [42:32] dimension, [43] saturated
);
    import rfe_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    logic    push_valid;
    rfe_op_t push_data;
    logic    queue_full;
    logic    queue_empty;
    logic    queue_pop;
    rfe_op_t queue_data;

    rfe_front #(
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_data     (push_data),
        .queue_full    (queue_full)
    );

    rfe_queue #(
        .WIDTH($bits(rfe_op_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push_valid),
        .wr_data (push_data),
        .full    (queue_full),
        .rd_en   (queue_pop),
        .rd_data (queue_data),
        .empty   (queue_empty)
    );

    rfe_back #(
        .MAX_DIM        (MAX_DIM),
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (queue_empty),
        .q_data        (queue_data),
        .q_pop         (queue_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the fixed-point Rastrigin fitness evaluator core.
`timescale 1ns / 1ps

module testbench;
    import rfe_pkg::*;

    localparam int MAX_DIM         = 1024;
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int N_DIRECTED      = 23;
    localparam int COORD_TARGET    = 1700;
    localparam int LONG_VECTOR_AT  = 600;
    localparam int HOLD_CYCLES     = 90;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_PRINTED     = 50;

    typedef struct packed {
        logic signed [FIT_W-1:0] fitness;
        logic [DIM_W-1:0]        dimension;
        logic                    saturated;
    } fitness_result_t;

    typedef struct packed {
        logic [COORD_W-1:0] coord;
        logic               last;
        logic               typed;
        fitness_result_t    want;
    } directed_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    fitness_result_t pending_results[$];
    int              cos_q12 [0:COS_TABLE_DEPTH];
    int              acc_sum      = 0;
    int              acc_count    = 0;
    bit              acc_overflow = 1'b0;
    int              error_count  = 0;
    int              results_seen = 0;
    int              coords_sent  = 0;
    bit              hold_request = 1'b0;

    // Typed expectations: zero, +-1.0, -8.0 and 0.5 are exact from the cosine endpoints.
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{16'h0000, 1'b1, 1'b1, '{32'sd0,       11'd1, 1'b0}},
        '{16'h1000, 1'b1, 1'b1, '{32'sd4096,    11'd1, 1'b0}},
        '{16'hF000, 1'b1, 1'b1, '{32'sd4096,    11'd1, 1'b0}},
        '{16'h8000, 1'b1, 1'b1, '{32'sd262144,  11'd1, 1'b0}},
        '{16'h7FFF, 1'b1, 1'b0, '0},
        '{16'h0800, 1'b1, 1'b1, '{32'sd82944,   11'd1, 1'b0}},
        '{16'h0400, 1'b1, 1'b0, '0},
        '{16'h0C00, 1'b1, 1'b0, '0},
        '{16'h0001, 1'b1, 1'b0, '0},
        '{16'hFFFF, 1'b1, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b1, 1'b1, '{32'sd0,       11'd3, 1'b0}},
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b1, 1'b1, '{32'sd1048576, 11'd4, 1'b0}},
        '{16'h5555, 1'b0, 1'b0, '0},
        '{16'hAAAA, 1'b0, 1'b0, '0},
        '{16'h03FF, 1'b0, 1'b0, '0},
        '{16'h0401, 1'b1, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b1, 1'b0, '0}
    };

    rastrigin_fitness_evaluator_core #(
        .MAX_DIM         (MAX_DIM),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [15:0] coord
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)     // [31:0] fitness, [42:32] dimension, [43] saturated
    );

    always #2 aclk = ~aclk;

    function automatic int saturate_add(input int a, input longint b);
        longint s;
        s = longint'(a) + b;
        if (s > longint'(32'sh7FFF_FFFF)) begin
            acc_overflow = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (s < -longint'(64'sh8000_0000)) begin
            acc_overflow = 1'b1;
            return 32'sh8000_0000;
        end
        return int'(s);
    endfunction

    // Quarter-wave lookup: bit 10 mirrors the offset, bits 11 xor 10 negate.
    function automatic int cos_of_phase(input logic [11:0] phase);
        int r;
        int m;
        int idx;
        r   = int'(phase[9:0]);
        m   = phase[10] ? 1024 - r : r;
        idx = (m * COS_TABLE_DEPTH + 512) >> 10;
        if (idx > COS_TABLE_DEPTH) begin
            idx = COS_TABLE_DEPTH;
        end
        return (phase[11] ^ phase[10]) ? -cos_q12[idx] : cos_q12[idx];
    endfunction

    function automatic bit fold_coordinate(input logic [COORD_W-1:0] coord, input logic last,
                                           output fitness_result_t res);
        longint x;
        longint sq;
        longint term;
        x    = longint'($signed(coord));
        sq   = (x * x + 2048) >>> 12;
        term = sq - 10 * longint'(cos_of_phase(coord[11:0]));
        acc_sum = saturate_add(acc_sum, term);
        if (acc_count < MAX_DIM) begin
            acc_count++;
        end else begin
            acc_overflow = 1'b1;
        end
        res = '0;
        if (!last) begin
            return 1'b0;
        end
        res.fitness   = saturate_add(acc_sum, 10 * longint'(acc_count) * ONE_Q12);
        res.dimension = DIM_W'(acc_count);
        res.saturated = acc_overflow;
        acc_sum      = 0;
        acc_count    = 0;
        acc_overflow = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return COORD_W'($urandom_range(0, 65535));
            5:             return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            6:             return COORD_W'($urandom_range(0, 63) << 10);
            default:       return COORD_W'(int'($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("MISMATCH t=%0t result %0d %s: got %0d expected %0d",
                     $time, results_seen, what, got, want);
        end
    endtask

    // Valid is left high after the transaction; the next call lowers it only for a gap.
    task automatic offer_coord(input logic [COORD_W-1:0] coord, input logic last, input int gap,
                               input logic typed, input fitness_result_t typed_want);
        fitness_result_t predicted;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= coord;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        coords_sent++;
        if (fold_coordinate(coord, last, predicted)) begin
            pending_results.push_back(typed ? typed_want : predicted);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("rastrigin_fitness_evaluator_core regression: fail");
        $finish;
    end

    initial begin
        int              gap;
        int              quiet_left;
        fitness_result_t got;
        fitness_result_t want;
        quiet_left = 0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (quiet_left > 0) begin
                quiet_left--;
                gap = 0;
            end else if ($urandom_range(0, 7) == 0) begin
                quiet_left = $urandom_range(5, 20);
                gap = 0;
            end else begin
                gap = $urandom_range(0, 18);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            results_seen++;
            got = '{m_axis_tdata[31:0], m_axis_tdata[42:32], m_axis_tdata[43]};
            if (pending_results.size() == 0) begin
                report_mismatch("transaction with nothing pending", got.fitness, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.fitness !== want.fitness)
                    report_mismatch("fitness", got.fitness, want.fitness);
                if (got.dimension !== want.dimension)
                    report_mismatch("dimension", got.dimension, want.dimension);
                if (got.saturated !== want.saturated)
                    report_mismatch("saturated", got.saturated, want.saturated);
            end
        end
    end

    initial begin
        logic [63:0] k;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        longint      acc;
        longint      v;
        int          n;
        int          row;
        int          len;
        int          i;
        bit          burst;
        bit          long_done;

        for (k = 0; k <= COS_TABLE_DEPTH; k++) begin
            t    = (k * HALF_PI_Q30 + COS_TABLE_DEPTH / 2) / COS_TABLE_DEPTH;
            t2   = (t * t) >> 30;
            term = 64'd1 << 30;
            acc  = longint'(term);
            for (n = 1; n <= 8; n++) begin
                term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            v = (acc > 0) ? ((acc + 131072) >>> 18) : 0;
            if (v > ONE_Q12) begin
                v = ONE_Q12;
            end
            cos_q12[k] = int'(v);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < N_DIRECTED; row++) begin
            offer_coord(directed_rows[row].coord, directed_rows[row].last,
                        $urandom_range(0, 18), directed_rows[row].typed,
                        directed_rows[row].want);
        end
        drain_results();

        // Back-pressure: receiver holds off while mostly single-coordinate vectors pour in.
        hold_request = 1'b1;
        for (i = 0; i < 40; i++) begin
            offer_coord(pick_coord(), $urandom_range(0, 3) != 0, 0, 1'b0, '0);
        end

        long_done = 1'b0;
        while (coords_sent < COORD_TARGET) begin
            if (!long_done && coords_sent >= LONG_VECTOR_AT) begin
                // overlong vector: count holds at the maximum and the flag is raised
                len = MAX_DIM + $urandom_range(1, 6);
                long_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(9, 40);
            end else begin
                len = $urandom_range(1, 8);
            end
            burst = ($urandom_range(0, 3) == 0);
            for (i = 0; i < len; i++) begin
                offer_coord(pick_coord(), i == len - 1, burst ? 0 : $urandom_range(0, 18),
                            1'b0, '0);
            end
            if ($urandom_range(0, 29) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("rastrigin_fitness_evaluator_core regression: pass");
        end else begin
            $display("rastrigin_fitness_evaluator_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: rastrigin_fitness_evaluator_core.f
rtl/rfe_pkg.sv
rtl/rfe_front.sv
rtl/rfe_queue.sv
rtl/rfe_back.sv
rtl/rastrigin_fitness_evaluator_core.sv
dv/testbench.sv
